// ----- hdl/lsi_pkg.sv -----
// Package for the line skew interpolator: run types, widths and line limits.
// No dependencies; used by every module of the block.
`default_nettype none
package lsi_pkg;

   localparam int PIX_W    = 32;
   localparam int CH_W     = 8;
   localparam int NUM_CH   = PIX_W / CH_W;
   localparam int SHIFT_W  = 15;
   localparam int WEIGHT_W = 8;
   localparam int LEN_W    = 14;
   localparam int POS_W    = 16;
   localparam int NUM_RUNS = 4;

   localparam logic [LEN_W-1:0] MAX_LINE = LEN_W'(8192);

   // Run slots in output order
   localparam int RUN_LEAD  = 0;
   localparam int RUN_LAND  = 1;
   localparam int RUN_EDGE  = 2;
   localparam int RUN_TRAIL = 3;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic [LEN_W-1:0] count;
      logic             done;
   } run_type;

   typedef struct packed {
      logic [NUM_RUNS-1:0] valid;
      run_type [NUM_RUNS-1:0] runs;
   } run_bundle_type;

endpackage
`default_nettype wire

// ----- hdl/lsi_blend.sv -----
// Per-channel blend against background and edge-corrected landing pixel.
// Depends on lsi_pkg.
`default_nettype none
module lsi_blend
   import lsi_pkg::*;
(
   input  wire logic [PIX_W-1:0]    src_pixel,
   input  wire logic [PIX_W-1:0]    bg_pixel,
   input  wire logic [WEIGHT_W-1:0] weight,
   input  wire logic [PIX_W-1:0]    prev_left,
   output logic      [PIX_W-1:0]    left_pixel,
   output logic      [PIX_W-1:0]    land_pixel
);

   logic [WEIGHT_W:0] inv_weight;

   assign inv_weight = (WEIGHT_W+1)'(1 << WEIGHT_W) - {1'b0, weight};

   always_comb begin
      logic [2*CH_W:0] acc;
      logic [CH_W-1:0] left_ch;
      logic [CH_W-1:0] diff_ch;
      left_pixel = '0;
      land_pixel = '0;
      for (int c = 0; c < NUM_CH; c++) begin
         acc = (2*CH_W+1)'(src_pixel[c*CH_W +: CH_W] * weight)
             + (2*CH_W+1)'(bg_pixel[c*CH_W +: CH_W] * inv_weight);
         left_ch = acc[2*CH_W-1:CH_W];
         // wrap each channel mod 256
         diff_ch = left_ch - prev_left[c*CH_W +: CH_W];
         left_pixel[c*CH_W +: CH_W] = left_ch;
         land_pixel[c*CH_W +: CH_W] = src_pixel[c*CH_W +: CH_W] - diff_ch;
      end
   end

endmodule
`default_nettype wire

// ----- hdl/lsi_line_ctrl.sv -----
// Line state (position, previous left, weight, length) and run generation.
// Depends on lsi_pkg and lsi_blend.
`default_nettype none
module lsi_line_ctrl
   import lsi_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                accept,
   input  wire logic [PIX_W-1:0]    bg_pixel,
   input  wire logic [PIX_W-1:0]    src_pixel,
   input  wire logic                first_of_line,
   input  wire logic                last_of_line,
   input  wire logic [SHIFT_W-1:0]  shift,
   input  wire logic [WEIGHT_W-1:0] blend_weight,
   input  wire logic [LEN_W-1:0]    out_length,
   output run_bundle_type           bundle
);

   logic signed [POS_W-1:0] next_position_ff, next_position_in;
   logic [PIX_W-1:0]        previous_left_ff, previous_left_in;
   logic [WEIGHT_W-1:0]     line_weight_ff, line_weight_in;
   logic [LEN_W-1:0]        line_length_ff, line_length_in;

   logic signed [POS_W-1:0] shift_ext, pos_cur, pos_after, len_s, trail_start;
   logic [LEN_W-1:0]        clamped_len;
   logic [PIX_W-1:0]        prev_cur, left_pixel, land_pixel;
   logic                    lead_v, land_v, edge_v, trail_v;
   logic [LEN_W-1:0]        lead_count;

   assign shift_ext = {shift[SHIFT_W-1], shift};

   always_comb begin
      clamped_len = out_length;
      if (out_length == '0) begin
         clamped_len = LEN_W'(1);
      end else if (out_length > MAX_LINE) begin
         clamped_len = MAX_LINE;
      end
   end

   assign line_weight_in = first_of_line ? blend_weight : line_weight_ff;
   assign line_length_in = first_of_line ? clamped_len : line_length_ff;
   assign prev_cur       = first_of_line ? bg_pixel : previous_left_ff;
   assign pos_cur        = first_of_line ? shift_ext : next_position_ff;
   assign len_s          = signed'(POS_W'(line_length_in));

   lsi_blend u_blend (
      .src_pixel  (src_pixel),
      .bg_pixel   (bg_pixel),
      .weight     (line_weight_in),
      .prev_left  (prev_cur),
      .left_pixel (left_pixel),
      .land_pixel (land_pixel)
   );

   // saturate the position at the line length
   assign pos_after        = (pos_cur < len_s) ? pos_cur + POS_W'(1) : pos_cur;
   assign next_position_in = pos_after;
   assign previous_left_in = left_pixel;

   assign lead_v  = first_of_line && (shift_ext > 0);
   assign lead_count = (shift_ext > signed'(POS_W'(clamped_len))) ? clamped_len
                                                                 : shift[LEN_W-1:0];
   assign land_v  = (pos_cur >= 0) && (pos_cur < len_s);
   assign edge_v  = last_of_line && (pos_after < len_s) && (pos_after >= 0);
   assign trail_start = (pos_after >= 0) ? pos_after + POS_W'(1) : '0;
   assign trail_v = last_of_line && (pos_after < len_s) && (trail_start < len_s);

   always_comb begin
      logic signed [POS_W-1:0] trail_count;
      trail_count = len_s - trail_start;
      bundle.valid = {trail_v, edge_v, land_v, lead_v};
      bundle.runs[RUN_LEAD]  = '{pixel: bg_pixel,   count: lead_count,   done: 1'b0};
      bundle.runs[RUN_LAND]  = '{pixel: land_pixel, count: LEN_W'(1),    done: 1'b0};
      bundle.runs[RUN_EDGE]  = '{pixel: left_pixel, count: LEN_W'(1),    done: 1'b0};
      bundle.runs[RUN_TRAIL] = '{pixel: bg_pixel,
                                 count: trail_count[LEN_W-1:0], done: 1'b0};
      // mark the final run of the line
      bundle.runs[RUN_TRAIL].done = last_of_line && trail_v;
      bundle.runs[RUN_EDGE].done  = last_of_line && edge_v && !trail_v;
      bundle.runs[RUN_LAND].done  = last_of_line && land_v && !edge_v && !trail_v;
      bundle.runs[RUN_LEAD].done  = last_of_line && lead_v && !land_v && !edge_v
                                    && !trail_v;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_position_ff <= '0;
         previous_left_ff <= '0;
         line_weight_ff   <= '0;
         line_length_ff   <= '0;
      end else if (accept) begin
         next_position_ff <= next_position_in;
         previous_left_ff <= previous_left_in;
         line_weight_ff   <= line_weight_in;
         line_length_ff   <= line_length_in;
      end
   end

endmodule
`default_nettype wire

// ----- hdl/lsi_run_drain.sv -----
// Result register holding up to four runs of one item; drains one run a cycle while out_ready is high.
// Depends on lsi_pkg.
`default_nettype none
module lsi_run_drain
   import lsi_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire run_bundle_type bundle,
   input  wire logic     load_valid,
   output logic          load_ready,
   output logic          out_valid,
   input  wire logic     out_ready,
   output run_type       out_run
);

   logic [NUM_RUNS-1:0] pending_ff, pending_in;
   run_type [NUM_RUNS-1:0] runs_ff, runs_in;
   logic [NUM_RUNS-1:0] sel_onehot;
   logic                last_pending;

   // lowest pending slot goes first
   assign sel_onehot   = pending_ff & (~pending_ff + NUM_RUNS'(1));
   assign last_pending = (pending_ff == sel_onehot);
   assign out_valid    = |pending_ff;
   assign load_ready   = !out_valid || (last_pending && out_ready);

   always_comb begin
      out_run = '0;
      for (int i = 0; i < NUM_RUNS; i++) begin
         if (sel_onehot[i]) begin
            out_run = runs_ff[i];
         end
      end
   end

   always_comb begin
      pending_in = pending_ff;
      runs_in    = runs_ff;
      if (out_valid && out_ready) begin
         pending_in = pending_ff & ~sel_onehot;
      end
      if (load_valid && load_ready) begin
         pending_in = bundle.valid;
         runs_in    = bundle.runs;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      runs_ff <= runs_in;
   end

endmodule
`default_nettype wire

// ----- hdl/line_skew_interpolator_top.sv -----
// Line skew interpolator: one shear pass of a three-shear rotation.
// An item's first run is registered and appears in the cycle after its acceptance.
// Throughput: one item per cycle while each item yields at most one run and the
// receiver is ready; a multi-run item holds the register until its last run goes.
// Reset (synchronous, active high) clears line state, background and pending runs.
`default_nettype none
module line_skew_interpolator_top
   import lsi_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // source items
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [31:0] src_pixel, [46:32] shift, [54:47] blend_weight, [68:55] out_length
   input  wire logic [71:0] req_tdata,
   // [0] first_of_line
   input  wire logic        req_tuser,
   input  wire logic        req_tlast,     // last_of_line
   // output runs
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [31:0] out_pixel, [45:32] repeat_res, [47:46] zero
   output logic [47:0]      rsp_tdata,
   output logic             rsp_tlast,     // line_done
   // background color register
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [31:0] csr_data
);

   logic [PIX_W-1:0] background_ff, background_in;
   logic             req_accept;
   run_bundle_type   bundle;
   run_type          out_run;

   // Background is always writable; the user must write it only while the block is idle; not enforced.
   assign csr_ready     = 1'b1;
   assign background_in = (csr_valid && csr_ready) ? csr_data : background_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         background_ff <= '0;
      end else begin
         background_ff <= background_in;
      end
   end

   assign req_accept = req_tvalid && req_tready;

   // Line state updates and all runs for the item are formed in one pass.
   lsi_line_ctrl u_line_ctrl (
      .clock         (clock),
      .reset         (reset),
      .accept        (req_accept),
      .bg_pixel      (background_ff),
      .src_pixel     (req_tdata[31:0]),
      .first_of_line (req_tuser),
      .last_of_line  (req_tlast),
      .shift         (req_tdata[46:32]),
      .blend_weight  (req_tdata[54:47]),
      .out_length    (req_tdata[68:55]),
      .bundle        (bundle)
   );

   // Hold the item's runs and hand them out in order, one per cycle while rsp_tready is high.
   lsi_run_drain u_run_drain (
      .clock      (clock),
      .reset      (reset),
      .bundle     (bundle),
      .load_valid (req_tvalid),
      .load_ready (req_tready),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_run    (out_run)
   );

   assign rsp_tdata = {2'b00, out_run.count, out_run.pixel};
   assign rsp_tlast = out_run.done;

endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
// Testbench for line_skew_interpolator_top: drives source items, predicts output runs.
// Depends on lsi_pkg and the RTL of the block; needs nothing else.
`timescale 1ns / 1ps
module tb_top;
   import lsi_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 4;    // margin after the block goes idle
   localparam int DRAIN_CYCLES  = 16;
   localparam int LONG_HOLD     = 400;
   localparam int REPORT_LIMIT  = 10;

   typedef struct {
      logic [PIX_W-1:0]    pixel;
      logic                first;
      logic                last;
      logic [SHIFT_W-1:0]  shift;
      logic [WEIGHT_W-1:0] weight;
      logic [LEN_W-1:0]    length;
   } source_item_type;

   typedef enum {READY_ALWAYS, READY_CADENCE, READY_COIN, READY_SPARSE} ready_mode_type;

   // DUT-facing signals; every input starts at a known value
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata  = '0;
   logic        req_tuser  = 1'b0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_data   = '0;

   // Source items waiting for the driver, runs waiting for the monitor
   source_item_type pending_items[$];
   run_type         expected_runs[$];

   // Shadow of the block's line state and background register
   logic [PIX_W-1:0]          bg_color    = '0;
   logic signed [POS_W-1:0]   line_pos    = '0;
   logic [PIX_W-1:0]          prev_left   = '0;
   logic [WEIGHT_W-1:0]       line_weight = '0;
   logic [LEN_W-1:0]          line_len    = '0;

   logic req_taken = 1'b0;
   int   mismatch_count = 0;
   int   cycle_count = 0;
   int   burst_left = 0;
   int   gap_left = 0;
   int   holds_asked = 0;
   int   holds_served = 0;
   int   hold_left = 0;
   int   mode_left = 0;
   int   cadence = 0;
   ready_mode_type ready_mode = READY_ALWAYS;

   line_skew_interpolator_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------
   function automatic run_type make_run(logic [PIX_W-1:0] value, int reps);
      run_type r;
      r.pixel = value;
      r.count = LEN_W'(reps);
      r.done  = 1'b0;
      return r;
   endfunction

   // Per channel: (src*w + bg*(256-w)) >> 8
   function automatic logic [PIX_W-1:0] blend_pixel(logic [PIX_W-1:0] src,
                                                    logic [PIX_W-1:0] bg,
                                                    logic [WEIGHT_W-1:0] w);
      logic [PIX_W-1:0] mix;
      int sc;
      int bc;
      for (int c = 0; c < NUM_CH; c++) begin
         sc = int'(src[c*CH_W +: CH_W]);
         bc = int'(bg[c*CH_W +: CH_W]);
         mix[c*CH_W +: CH_W] = CH_W'((sc * int'(w) + bc * (256 - int'(w))) >> 8);
      end
      return mix;
   endfunction

   // Per channel subtraction, wrapping at 8 bits
   function automatic logic [PIX_W-1:0] channel_diff(logic [PIX_W-1:0] a,
                                                     logic [PIX_W-1:0] b);
      logic [PIX_W-1:0] d;
      for (int c = 0; c < NUM_CH; c++)
         d[c*CH_W +: CH_W] = a[c*CH_W +: CH_W] - b[c*CH_W +: CH_W];
      return d;
   endfunction

   // Advance the shadow line state by one source item and queue the runs it causes
   function automatic void shear_step(source_item_type it);
      run_type          runs[$];
      logic [LEN_W-1:0] len_latch;
      logic [PIX_W-1:0] left;
      int sh;
      int len;
      int pos;
      int start;
      sh = int'($signed(it.shift));
      if (it.first) begin
         len_latch = it.length;
         if (len_latch == '0) len_latch = LEN_W'(1);
         if (len_latch > MAX_LINE) len_latch = MAX_LINE;
         line_len    = len_latch;
         line_weight = it.weight;
         prev_left   = bg_color;
         line_pos    = POS_W'(sh);
         // leading background, clipped to the line
         if (sh > 0)
            runs.push_back(make_run(bg_color,
                                    (sh > int'(len_latch)) ? int'(len_latch) : sh));
      end
      len = int'(line_len);
      pos = int'(line_pos);
      left = blend_pixel(it.pixel, bg_color, line_weight);
      if (pos >= 0 && pos < len)
         runs.push_back(make_run(channel_diff(it.pixel, channel_diff(left, prev_left)), 1));
      prev_left = left;
      // saturate at the line length
      if (pos < len) pos++;
      line_pos = POS_W'(pos);
      if (it.last) begin
         if (pos < len) begin
            if (pos >= 0) begin
               runs.push_back(make_run(prev_left, 1));
               start = pos + 1;
            end else begin
               start = 0;
            end
            if (start < len) runs.push_back(make_run(bg_color, len - start));
         end
         // a last item that yields nothing marks no run as done
         if (runs.size() > 0) runs[runs.size()-1].done = 1'b1;
      end
      foreach (runs[i]) expected_runs.push_back(runs[i]);
   endfunction

   function automatic void note_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) $display("Mismatch: %s", what);
   endfunction

   // ---------------------------------------------------------------------
   // Monitor: sample both channels and the register port at the rising edge
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      source_item_type seen;
      run_type         want;
      run_type         got;
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         if (csr_valid && csr_ready) bg_color = csr_data;
         req_taken = req_tvalid && req_tready;
         if (req_taken) begin
            seen.pixel  = req_tdata[31:0];
            seen.shift  = req_tdata[46:32];
            seen.weight = req_tdata[54:47];
            seen.length = req_tdata[68:55];
            seen.first  = req_tuser;
            seen.last   = req_tlast;
            shear_step(seen);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.pixel = rsp_tdata[31:0];
            got.count = rsp_tdata[45:32];
            got.done  = rsp_tlast;
            if (expected_runs.size() == 0) begin
               note_mismatch($sformatf("run with none pending: pixel %h count %0d done %0b",
                                       got.pixel, got.count, got.done));
            end else begin
               want = expected_runs.pop_front();
               if (got.pixel !== want.pixel)
                  note_mismatch($sformatf("out_pixel expected %h actual %h",
                                          want.pixel, got.pixel));
               if (got.count !== want.count)
                  note_mismatch($sformatf("repeat_res expected %0d actual %0d",
                                          want.count, got.count));
               if (got.done !== want.done)
                  note_mismatch($sformatf("line_done expected %0b actual %0b",
                                          want.done, got.done));
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Driver: offer items in bursts, change inputs at the falling edge
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      source_item_type nxt;
      if (!reset && (!req_tvalid || req_taken)) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_items.size() > 0) begin
            nxt = pending_items.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {3'b000, nxt.length, nxt.weight, nxt.shift, nxt.pixel};
            req_tuser  <= nxt.first;
            req_tlast  <= nxt.last;
            if (burst_left > 0) burst_left--;
            // end of burst: pick the next burst length and the gap before it
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Receiver: stall on a changing pattern, plus a long hold on request
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (holds_served != holds_asked) begin
         holds_served = holds_asked;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            ready_mode = ready_mode_type'($urandom_range(0, 3));
            mode_left  = $urandom_range(8, 40);
         end
         mode_left--;
         cadence++;
         case (ready_mode)
            READY_ALWAYS:  rsp_tready <= 1'b1;
            READY_CADENCE: rsp_tready <= (cadence % 4) != 3;
            READY_COIN:    rsp_tready <= $urandom_range(0, 1);
            default:       rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   task automatic add_item(logic [PIX_W-1:0] pixel, logic first, logic last,
                           int sh, int weight, int length);
      source_item_type it;
      it.pixel  = pixel;
      it.first  = first;
      it.last   = last;
      it.shift  = SHIFT_W'(sh);
      it.weight = WEIGHT_W'(weight);
      it.length = LEN_W'(length);
      pending_items.push_back(it);
   endtask

   // One line: line fields on the first item, random filler on the rest
   task automatic add_line(int length, int sh, int weight, int npix, logic closed);
      for (int i = 0; i < npix; i++) begin
         if (i == 0)
            add_item($urandom, 1'b1, closed && (npix == 1), sh, weight, length);
         else
            add_item($urandom, 1'b0, closed && (i == npix - 1),
                     int'($urandom_range(0, 16384)) - 8192,
                     $urandom_range(0, 255), $urandom_range(1, 8192));
      end
   endtask

   task automatic queue_directed();
      // nothing lands or fills before the first line starts
      add_item(32'hFFFF_FFFF, 1'b0, 1'b0, 5, 255, 8);
      add_item(32'h0000_0000, 1'b0, 1'b1, -3, 0, 8);
      // zero weight, every pixel lands, last pixel ends exactly at the line end
      add_item(32'h0000_0000, 1'b1, 1'b0, 0, 0, 4);
      add_item(32'hFFFF_FFFF, 1'b0, 1'b0, 0, 0, 4);
      add_item(32'h8080_8080, 1'b0, 1'b0, 0, 0, 4);
      add_item(32'h7F7F_7F7F, 1'b0, 1'b1, 0, 0, 4);
      // leading fill, full weight, edge pixel at the last position
      add_item(32'h1234_5678, 1'b1, 1'b0, 2, 255, 6);
      add_item(32'hFEDC_BA98, 1'b0, 1'b0, 2, 255, 6);
      add_item(32'h00FF_00FF, 1'b0, 1'b1, 2, 255, 6);
      // negative shift: early pixels fall off the left, then edge and trailing fill
      add_item(32'hA5A5_A5A5, 1'b1, 1'b0, -2, 128, 5);
      add_item(32'h5A5A_5A5A, 1'b0, 1'b0, -2, 128, 5);
      add_item(32'hFF00_FF00, 1'b0, 1'b1, -2, 128, 5);
      // maximum length, shift equal to it: lead fill covers the whole line
      add_item(32'hDEAD_BEEF, 1'b1, 1'b1, 8192, 1, 8192);
      // shift of -8192, length above the maximum gets clamped
      add_item(32'hCAFE_F00D, 1'b1, 1'b1, -8192, 255, 16383);
      // zero length clamps to one pixel
      add_item(32'h0F0F_0F0F, 1'b1, 1'b1, 0, 64, 0);
      // position saturates, last item yields no run
      add_item(32'h1111_1111, 1'b1, 1'b0, 0, 200, 2);
      add_item(32'h2222_2222, 1'b0, 1'b0, 0, 200, 2);
      add_item(32'h3333_3333, 1'b0, 1'b1, 0, 200, 2);
      // one item causing all four runs
      add_item(32'h89AB_CDEF, 1'b1, 1'b1, 2, 77, 10);
      // shift past the line end: only the clipped lead fill
      add_item(32'h4444_4444, 1'b1, 1'b0, 5, 10, 3);
      add_item(32'h5555_5555, 1'b0, 1'b1, 5, 10, 3);
   endtask

   // Mostly well-formed lines with random content; some unclosed lines and loose items
   task automatic queue_random_lines(int target);
      int added;
      int kind;
      int length;
      int span;
      int sh;
      int npix;
      added = 0;
      while (added < target) begin
         kind = $urandom_range(0, 9);
         if (kind == 9) begin
            add_item($urandom, $urandom_range(0, 1), $urandom_range(0, 1),
                     int'($urandom_range(0, 16384)) - 8192,
                     $urandom_range(0, 255), $urandom_range(0, 16383));
            added++;
         end else begin
            case ($urandom_range(0, 9))
               0:       length = $urandom_range(0, 16383);
               1:       length = $urandom_range(1, 8192);
               default: length = $urandom_range(1, 20);
            endcase
            span = (length == 0 || length > 20) ? 20 : length;
            if ($urandom_range(0, 7) == 0)
               sh = int'($urandom_range(0, 16384)) - 8192;
            else
               sh = int'($urandom_range(0, 2 * span + 6)) - (span + 3);
            npix = $urandom_range(1, span + 4);
            add_line(length, sh, $urandom_range(0, 255), npix, kind != 8);
            added += npix;
         end
      end
   endtask

   // Wait until every item is in and every run is out, then let the block settle
   task automatic wait_until_idle();
      while (pending_items.size() != 0 || req_tvalid || expected_runs.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_background(logic [31:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // background at its reset value of zero
      queue_directed();
      wait_until_idle();

      write_background($urandom);
      queue_random_lines(45);
      // hold the receiver off while items keep coming, so the input stalls
      holds_asked++;
      wait_until_idle();

      write_background(32'hFFFF_FFFF);
      queue_random_lines(45);
      wait_until_idle();

      write_background(32'h0000_0000);
      queue_random_lines(45);
      wait_until_idle();

      write_background($urandom);
      queue_random_lines(45);
      wait_until_idle();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_runs.size() != 0)
         note_mismatch($sformatf("%0d runs never arrived", expected_runs.size()));
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hdl/lsi_pkg.sv
hdl/lsi_blend.sv
hdl/lsi_line_ctrl.sv
hdl/lsi_run_drain.sv
hdl/line_skew_interpolator_top.sv
bench/tb_top.sv
